>>> hdl/kf4_pkg.sv
package kf4_pkg;

  localparam int ST_BITS = 48;
  localparam int HALF_BITS = ST_BITS / 2;
  localparam int TS_BITS = 32;
  localparam int RF_DEPTH = 32;
  localparam int RF_AW = 5;
  localparam int PC_BITS = 7;

  localparam logic signed [ST_BITS-1:0] ST_MAX = {1'b0, {(ST_BITS-1){1'b1}}};
  localparam logic signed [ST_BITS-1:0] ST_MIN = {1'b1, {(ST_BITS-1){1'b0}}};

  localparam logic [PC_BITS-1:0] PC_UPD = 7'd0;
  localparam logic [PC_BITS-1:0] PC_OUT = 7'd59;
  localparam logic [PC_BITS-1:0] PC_OUT_END = 7'd62;
  localparam logic [PC_BITS-1:0] PC_RST = 7'd63;
  localparam logic [PC_BITS-1:0] PC_RST_END = 7'd68;

  localparam logic [RF_AW-1:0] TMP_BASE = 5'd12;

  typedef enum logic [2:0] {
    CFG_TIME_STEP,
    CFG_ACCEL_X,
    CFG_ACCEL_Y,
    CFG_START_X,
    CFG_START_Y,
    CFG_MEAS_VAR_POS,
    CFG_MEAS_VAR_VEL,
    CFG_INIT_VAR_POS
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_OPND,
    ST_MUL,
    ST_MFIN,
    ST_DIV,
    ST_DFIN,
    ST_WRITE
  } fsm_e;

  typedef enum logic [3:0] {
    U_MOV,
    U_ADD,
    U_SUB,
    U_HALF,
    U_MUL,
    U_DTM,
    U_DIV,
    U_OUTE,
    U_OUTV
  } uop_e;

  typedef enum logic [5:0] {
    O_SI, O_SJ, O_PA, O_PB, O_PC, O_PD,
    O_XP, O_XV, O_B2, O_C2, O_A2, O_S11, O_S22, O_BC, O_DET,
    O_K11, O_K12, O_K21, O_K22, O_EP, O_EV, O_X0, O_X1, O_X2,
    O_ACC, O_ZP, O_ZV, O_RPOS, O_RVEL, O_ST, O_IVP, O_VV0, O_ZERO
  } opnd_e;

  typedef struct packed {
    uop_e  op;
    opnd_e dst;
    opnd_e a;
    opnd_e b;
  } uinstr_t;

  // One axis of the update: prediction, gain, correction, then the outputs.
  // The restart sequence reloads one axis and joins the output steps.
  function automatic uinstr_t ucode(input logic [PC_BITS-1:0] pc);
    uinstr_t u;
    u = '{U_MOV, O_X2, O_ZERO, O_ZERO};
    case (pc)
      7'd0:  u = '{U_DTM, O_X0, O_ACC, O_ZERO};
      7'd1:  u = '{U_DTM, O_X1, O_SJ, O_ZERO};
      7'd2:  u = '{U_ADD, O_X1, O_SI, O_X1};
      7'd3:  u = '{U_DTM, O_X2, O_X0, O_ZERO};
      7'd4:  u = '{U_HALF, O_X2, O_X2, O_ZERO};
      7'd5:  u = '{U_ADD, O_XP, O_X1, O_X2};
      7'd6:  u = '{U_ADD, O_XV, O_SJ, O_X0};
      7'd7:  u = '{U_DTM, O_X0, O_PD, O_ZERO};
      7'd8:  u = '{U_ADD, O_B2, O_PB, O_X0};
      7'd9:  u = '{U_ADD, O_C2, O_PC, O_X0};
      7'd10: u = '{U_DTM, O_X0, O_PC, O_ZERO};
      7'd11: u = '{U_ADD, O_X0, O_PA, O_X0};
      7'd12: u = '{U_DTM, O_X1, O_B2, O_ZERO};
      7'd13: u = '{U_ADD, O_A2, O_X0, O_X1};
      7'd14: u = '{U_ADD, O_S11, O_A2, O_RPOS};
      7'd15: u = '{U_ADD, O_S22, O_PD, O_RVEL};
      7'd16: u = '{U_MUL, O_X0, O_S11, O_S22};
      7'd17: u = '{U_MUL, O_BC, O_B2, O_C2};
      7'd18: u = '{U_SUB, O_DET, O_X0, O_BC};
      7'd19: u = '{U_MUL, O_X0, O_A2, O_S22};
      7'd20: u = '{U_SUB, O_X0, O_X0, O_BC};
      7'd21: u = '{U_DIV, O_K11, O_X0, O_DET};
      7'd22: u = '{U_MUL, O_X0, O_B2, O_S11};
      7'd23: u = '{U_MUL, O_X1, O_A2, O_B2};
      7'd24: u = '{U_SUB, O_X0, O_X0, O_X1};
      7'd25: u = '{U_DIV, O_K12, O_X0, O_DET};
      7'd26: u = '{U_MUL, O_X0, O_C2, O_S22};
      7'd27: u = '{U_MUL, O_X1, O_PD, O_C2};
      7'd28: u = '{U_SUB, O_X0, O_X0, O_X1};
      7'd29: u = '{U_DIV, O_K21, O_X0, O_DET};
      7'd30: u = '{U_MUL, O_X0, O_PD, O_S11};
      7'd31: u = '{U_SUB, O_X0, O_X0, O_BC};
      7'd32: u = '{U_DIV, O_K22, O_X0, O_DET};
      7'd33: u = '{U_SUB, O_EP, O_ZP, O_XP};
      7'd34: u = '{U_SUB, O_EV, O_ZV, O_XV};
      7'd35: u = '{U_MUL, O_X0, O_K11, O_EP};
      7'd36: u = '{U_ADD, O_X0, O_XP, O_X0};
      7'd37: u = '{U_MUL, O_X1, O_K12, O_EV};
      7'd38: u = '{U_ADD, O_SI, O_X0, O_X1};
      7'd39: u = '{U_MUL, O_X0, O_K21, O_EP};
      7'd40: u = '{U_ADD, O_X0, O_XV, O_X0};
      7'd41: u = '{U_MUL, O_X1, O_K22, O_EV};
      7'd42: u = '{U_ADD, O_SJ, O_X0, O_X1};
      7'd43: u = '{U_MUL, O_X0, O_K11, O_A2};
      7'd44: u = '{U_MUL, O_X1, O_K12, O_C2};
      7'd45: u = '{U_ADD, O_X0, O_X0, O_X1};
      7'd46: u = '{U_SUB, O_PA, O_A2, O_X0};
      7'd47: u = '{U_MUL, O_X0, O_K11, O_B2};
      7'd48: u = '{U_MUL, O_X1, O_K12, O_PD};
      7'd49: u = '{U_ADD, O_X0, O_X0, O_X1};
      7'd50: u = '{U_SUB, O_PB, O_B2, O_X0};
      7'd51: u = '{U_MUL, O_X0, O_K21, O_A2};
      7'd52: u = '{U_MUL, O_X1, O_K22, O_C2};
      7'd53: u = '{U_ADD, O_X0, O_X0, O_X1};
      7'd54: u = '{U_SUB, O_PC, O_C2, O_X0};
      7'd55: u = '{U_MUL, O_X0, O_K21, O_B2};
      7'd56: u = '{U_MUL, O_X1, O_K22, O_PD};
      7'd57: u = '{U_ADD, O_X0, O_X0, O_X1};
      7'd58: u = '{U_SUB, O_PD, O_PD, O_X0};
      7'd59: u = '{U_OUTE, O_SI, O_SI, O_ZERO};
      7'd60: u = '{U_OUTE, O_SJ, O_SJ, O_ZERO};
      7'd61: u = '{U_OUTV, O_PA, O_PA, O_ZERO};
      7'd62: u = '{U_OUTV, O_PD, O_PD, O_ZERO};
      7'd63: u = '{U_MOV, O_SI, O_ST, O_ZERO};
      7'd64: u = '{U_MOV, O_SJ, O_ZERO, O_ZERO};
      7'd65: u = '{U_MOV, O_PA, O_IVP, O_ZERO};
      7'd66: u = '{U_MOV, O_PB, O_ZERO, O_ZERO};
      7'd67: u = '{U_MOV, O_PC, O_ZERO, O_ZERO};
      7'd68: u = '{U_MOV, O_PD, O_VV0, O_ZERO};
      default: ;
    endcase
    return u;
  endfunction

  function automatic logic [RF_AW-1:0] rf_addr(input opnd_e o, input logic ax);
    logic [RF_AW-1:0] a;
    a = '0;
    case (o)
      O_SI: a = RF_AW'(ax);
      O_SJ: a = RF_AW'(2) + RF_AW'(ax);
      O_PA: a = RF_AW'(4) + RF_AW'({ax, 2'b00});
      O_PB: a = RF_AW'(5) + RF_AW'({ax, 2'b00});
      O_PC: a = RF_AW'(6) + RF_AW'({ax, 2'b00});
      O_PD: a = RF_AW'(7) + RF_AW'({ax, 2'b00});
      default: begin
        if (o >= O_XP && o <= O_X2) a = TMP_BASE + RF_AW'(o - O_XP);
      end
    endcase
    return a;
  endfunction

endpackage

>>> hdl/kf4_ram.sv
module kf4_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

>>> hdl/kalman_filter_4state_step.sv
// Two-axis constant-velocity Kalman filter that takes one measurement word
// (x, y, vx, vy) and returns one word of filtered state and variance diagonal.
// All multiplies and divides share one multiply/divide unit under a microcode
// sequencer, so in_ready_o stays low while a word is in work. The four
// restoring divisions per axis, one quotient bit per cycle, take the largest
// share of an update word's time. After reset the block runs the restart
// sequence once before it takes the first word. Configuration writes are
// taken at any time but must only be issued while the block is idle.
module kalman_filter_4state_step import kf4_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16,
  localparam int CW = (WORD_BITS > TS_BITS) ? WORD_BITS : TS_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [CW-1:0]        cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 restart_i,
  input  logic [WORD_BITS-1:0] meas_x_i,
  input  logic [WORD_BITS-1:0] meas_y_i,
  input  logic [WORD_BITS-1:0] meas_vx_i,
  input  logic [WORD_BITS-1:0] meas_vy_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WORD_BITS-1:0] est_x_o,
  output logic [WORD_BITS-1:0] est_y_o,
  output logic [WORD_BITS-1:0] est_vx_o,
  output logic [WORD_BITS-1:0] est_vy_o,
  output logic [WORD_BITS-2:0] var_x_o,
  output logic [WORD_BITS-2:0] var_y_o,
  output logic [WORD_BITS-2:0] var_vx_o,
  output logic [WORD_BITS-2:0] var_vy_o
);

  localparam int NW = ST_BITS + FRAC_BITS;
  localparam int CNT_BITS = $clog2(NW);
  localparam int PROD_BITS = 2 * ST_BITS;
  localparam logic signed [ST_BITS-1:0] VV0 =
    ST_BITS'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic signed [ST_BITS-1:0] EST_HI =
    ST_BITS'((64'd1 << (WORD_BITS - 1)) - 64'd1);
  localparam logic signed [ST_BITS-1:0] EST_LO = -EST_HI - 1;
  localparam logic signed [ST_BITS:0] SAT_HI = {1'b0, ST_MAX};
  localparam logic signed [ST_BITS:0] SAT_LO = -SAT_HI;

  fsm_e state_q, state_d;
  logic [PC_BITS-1:0] pc_q, pc_d;
  logic ax_q, ax_d;
  logic restart_q, restart_d;
  logic init_q, init_d;
  logic out_valid_q, out_valid_d;

  logic [TS_BITS-1:0]   time_step_q;
  logic [WORD_BITS-1:0] accel_x_q, accel_y_q, start_x_q, start_y_q;
  logic [WORD_BITS-2:0] meas_var_pos_q, meas_var_vel_q, init_var_pos_q;
  logic [WORD_BITS-1:0] meas_x_q, meas_y_q, meas_vx_q, meas_vy_q;

  logic signed [ST_BITS-1:0] opa_q, opb_q, res_q;
  logic [ST_BITS-1:0] ma_q, mb_q;
  logic neg_q;
  logic [PROD_BITS-1:0] acc_q;
  logic [1:0] part_q;
  logic [NW-1:0] num_q, quo_q;
  logic [ST_BITS-2:0] rem_q;
  logic [CNT_BITS-1:0] cnt_q;

  logic [WORD_BITS-1:0] est_q [4];
  logic [WORD_BITS-2:0] var_q [4];

  uinstr_t ui;
  logic ui_out, stall, rf_we, is_dtm;
  logic [ST_BITS-1:0] rd_a, rd_b;
  logic signed [ST_BITS-1:0] opa_v, opb_v, wv;
  logic [ST_BITS-1:0] ma_v, mb_v;
  logic [HALF_BITS-1:0] ah, bh;
  logic [ST_BITS-1:0] pp;
  logic [PROD_BITS-1:0] pp_sh, rsum, rsh;
  logic [ST_BITS-1:0] mmag, dmag, hmag;
  logic [ST_BITS-1:0] rem2;
  logic [ST_BITS-1:0] rem_sub;
  logic ge;
  logic signed [ST_BITS:0] s49;
  logic [1:0] oidx;

  function automatic logic signed [ST_BITS-1:0] sx(input logic [WORD_BITS-1:0] w);
    logic signed [ST_BITS-1:0] e;
    e = ST_BITS'($signed(w));
    if (e == ST_MIN) e = -ST_MAX;
    return e;
  endfunction

  function automatic logic [ST_BITS-1:0] absv(input logic signed [ST_BITS-1:0] v);
    return v[ST_BITS-1] ? ST_BITS'(-v) : ST_BITS'(v);
  endfunction

  function automatic logic signed [ST_BITS-1:0] pick(input opnd_e o,
                                                     input logic [ST_BITS-1:0] rd);
    logic signed [ST_BITS-1:0] v;
    case (o)
      O_ACC:  v = ax_q ? sx(accel_y_q) : sx(accel_x_q);
      O_ZP:   v = ax_q ? sx(meas_y_q) : sx(meas_x_q);
      O_ZV:   v = ax_q ? sx(meas_vy_q) : sx(meas_vx_q);
      O_RPOS: v = ST_BITS'(meas_var_pos_q);
      O_RVEL: v = ST_BITS'(meas_var_vel_q);
      O_ST:   v = ax_q ? sx(start_y_q) : sx(start_x_q);
      O_IVP:  v = ST_BITS'(init_var_pos_q);
      O_VV0:  v = VV0;
      O_ZERO: v = '0;
      default: v = $signed(rd);
    endcase
    return v;
  endfunction

  kf4_ram #(.WIDTH(ST_BITS), .DEPTH(RF_DEPTH)) u_rf (
    .clk_i,
    .we_i      (rf_we),
    .waddr_i   (rf_addr(ui.dst, ax_q)),
    .wdata_i   (wv),
    .raddr_a_i (rf_addr(ui.a, ax_q)),
    .raddr_b_i (rf_addr(ui.b, ax_q)),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  assign ui = ucode(pc_q);
  assign ui_out = (ui.op == U_OUTE) || (ui.op == U_OUTV);
  assign is_dtm = (ui.op == U_DTM);
  assign stall = (state_q == ST_WRITE) && ui_out && out_valid_q;
  assign rf_we = (state_q == ST_WRITE) && !ui_out;
  assign oidx = {(ui.dst == O_SJ) || (ui.dst == O_PD), ax_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_READ;
      pc_q        <= PC_RST;
      ax_q        <= 1'b0;
      restart_q   <= 1'b1;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      ax_q        <= ax_d;
      restart_q   <= restart_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    ax_d        = ax_q;
    restart_d   = restart_q;
    init_d      = init_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d   = ST_READ;
          ax_d      = 1'b0;
          restart_d = restart_i;
          pc_d      = restart_i ? PC_RST : PC_UPD;
        end
      end
      ST_READ: state_d = ST_OPND;
      ST_OPND: begin
        case (ui.op)
          U_MUL, U_DTM: state_d = ST_MUL;
          U_DIV:        state_d = ST_DIV;
          default:      state_d = ST_WRITE;
        endcase
      end
      ST_MUL: if (part_q == 2'd3) state_d = ST_MFIN;
      ST_MFIN: state_d = ST_WRITE;
      ST_DIV: if (cnt_q == CNT_BITS'(NW - 1)) state_d = ST_DFIN;
      ST_DFIN: state_d = ST_WRITE;
      ST_WRITE: begin
        if (!stall) begin
          state_d = ST_READ;
          if (pc_q == PC_OUT_END) begin
            if (!ax_q) begin
              ax_d = 1'b1;
              pc_d = restart_q ? PC_RST : PC_UPD;
            end else begin
              ax_d    = 1'b0;
              state_d = ST_IDLE;
              init_d  = 1'b0;
              if (!init_q) out_valid_d = 1'b1;
            end
          end else if (pc_q == PC_RST_END) begin
            pc_d = PC_OUT;
          end else begin
            pc_d = pc_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    opa_v = pick(ui.a, rd_a);
    opb_v = pick(ui.b, rd_b);
    ma_v  = absv(opa_v);
    mb_v  = is_dtm ? ST_BITS'(time_step_q) : absv(opb_v);

    ah = part_q[0] ? ma_q[ST_BITS-1:HALF_BITS] : ma_q[HALF_BITS-1:0];
    bh = part_q[1] ? mb_q[ST_BITS-1:HALF_BITS] : mb_q[HALF_BITS-1:0];
    pp = ah * bh;
    case ({1'b0, part_q[0]} + {1'b0, part_q[1]})
      2'd0:    pp_sh = PROD_BITS'(pp);
      2'd1:    pp_sh = PROD_BITS'(pp) << HALF_BITS;
      default: pp_sh = PROD_BITS'(pp) << ST_BITS;
    endcase

    rsum = acc_q + (is_dtm ? (PROD_BITS'(1) << (TS_BITS - 1))
                           : (PROD_BITS'(1) << (FRAC_BITS - 1)));
    rsh  = is_dtm ? (rsum >> TS_BITS) : (rsum >> FRAC_BITS);
    mmag = (rsh > PROD_BITS'(ST_MAX)) ? ST_MAX : rsh[ST_BITS-1:0];

    rem2    = {rem_q, num_q[NW-1]};
    ge      = rem2 >= mb_q;
    rem_sub = rem2 - mb_q;
    dmag = (quo_q > NW'(ST_MAX)) ? ST_MAX : quo_q[ST_BITS-1:0];
    if (mb_q == '0) dmag = '0;

    hmag = (ma_q + 1'b1) >> 1;
    s49  = '0;
    case (ui.op)
      U_MOV: wv = opa_q;
      U_ADD, U_SUB: begin
        s49 = (ui.op == U_ADD) ? ({opa_q[ST_BITS-1], opa_q} + {opb_q[ST_BITS-1], opb_q})
                               : ({opa_q[ST_BITS-1], opa_q} - {opb_q[ST_BITS-1], opb_q});
        if (s49 > SAT_HI) wv = ST_MAX;
        else if (s49 < SAT_LO) wv = -ST_MAX;
        else wv = s49[ST_BITS-1:0];
      end
      U_HALF: wv = neg_q ? -$signed(hmag) : $signed(hmag);
      default: wv = res_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      meas_x_q  <= meas_x_i;
      meas_y_q  <= meas_y_i;
      meas_vx_q <= meas_vx_i;
      meas_vy_q <= meas_vy_i;
    end
    case (state_q)
      ST_OPND: begin
        opa_q  <= opa_v;
        opb_q  <= opb_v;
        ma_q   <= ma_v;
        mb_q   <= mb_v;
        neg_q  <= (is_dtm || ui.op == U_HALF) ? opa_v[ST_BITS-1]
                                               : (opa_v[ST_BITS-1] ^ opb_v[ST_BITS-1]);
        acc_q  <= '0;
        part_q <= '0;
        num_q  <= (NW'(ma_v) << FRAC_BITS) + NW'(mb_v >> 1);
        rem_q  <= '0;
        quo_q  <= '0;
        cnt_q  <= '0;
      end
      ST_MUL: begin
        acc_q  <= acc_q + pp_sh;
        part_q <= part_q + 1'b1;
      end
      ST_MFIN: res_q <= neg_q ? -$signed(mmag) : $signed(mmag);
      ST_DIV: begin
        rem_q <= ge ? rem_sub[ST_BITS-2:0] : rem2[ST_BITS-2:0];
        quo_q <= {quo_q[NW-2:0], ge};
        num_q <= num_q << 1;
        cnt_q <= cnt_q + 1'b1;
      end
      ST_DFIN: res_q <= neg_q ? -$signed(dmag) : $signed(dmag);
      ST_WRITE: begin
        if (ui.op == U_OUTE && !out_valid_q) begin
          if (opa_q > EST_HI) est_q[oidx] <= EST_HI[WORD_BITS-1:0];
          else if (opa_q < EST_LO) est_q[oidx] <= EST_LO[WORD_BITS-1:0];
          else est_q[oidx] <= opa_q[WORD_BITS-1:0];
        end
        if (ui.op == U_OUTV && !out_valid_q) begin
          if (opa_q[ST_BITS-1]) var_q[oidx] <= '0;
          else if (opa_q > EST_HI) var_q[oidx] <= EST_HI[WORD_BITS-2:0];
          else var_q[oidx] <= opa_q[WORD_BITS-2:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q    <= 32'd4294967;
      accel_x_q      <= WORD_BITS'(64'd2 << FRAC_BITS);
      accel_y_q      <= WORD_BITS'(64'd2 << FRAC_BITS);
      start_x_q      <= WORD_BITS'(64'd1 << FRAC_BITS);
      start_y_q      <= WORD_BITS'(64'd1 << FRAC_BITS);
      meas_var_pos_q <= (WORD_BITS-1)'(64'd9 << FRAC_BITS);
      meas_var_vel_q <= (WORD_BITS-1)'(VV0);
      init_var_pos_q <= (WORD_BITS-1)'(64'd500 << FRAC_BITS);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TIME_STEP:    time_step_q    <= cfg_data_i[TS_BITS-1:0];
        CFG_ACCEL_X:      accel_x_q      <= cfg_data_i[WORD_BITS-1:0];
        CFG_ACCEL_Y:      accel_y_q      <= cfg_data_i[WORD_BITS-1:0];
        CFG_START_X:      start_x_q      <= cfg_data_i[WORD_BITS-1:0];
        CFG_START_Y:      start_y_q      <= cfg_data_i[WORD_BITS-1:0];
        CFG_MEAS_VAR_POS: meas_var_pos_q <= cfg_data_i[WORD_BITS-2:0];
        CFG_MEAS_VAR_VEL: meas_var_vel_q <= cfg_data_i[WORD_BITS-2:0];
        CFG_INIT_VAR_POS: init_var_pos_q <= cfg_data_i[WORD_BITS-2:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign est_x_o  = est_q[0];
  assign est_y_o  = est_q[1];
  assign est_vx_o = est_q[2];
  assign est_vy_o = est_q[3];
  assign var_x_o  = var_q[0];
  assign var_y_o  = var_q[1];
  assign var_vx_o = var_q[2];
  assign var_vy_o = var_q[3];

endmodule

>>> hdl/kf4_checker.sv
module kf4_checker #(
  parameter int WORD_BITS = 32
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [WORD_BITS-1:0] est_x_o,
  input logic [WORD_BITS-2:0] var_x_o
);

  // A word occupies the block, so it cannot take another in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice in a row");

  // No result can appear the cycle after a word is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(est_x_o) && $stable(var_x_o))
    else $error("output word changed while stalled");

endmodule

bind kalman_filter_4state_step kf4_checker #(.WORD_BITS(WORD_BITS)) u_kf4_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .est_x_o     (est_x_o),
  .var_x_o     (var_x_o)
);
